/* rtl/core/tspl_pkg.sv */
// ============================================================================
// tspl_pkg: shared types and constants of the twinkling star pool.
// Holds the sequencer states, the slot record, the colour table and the
// small arithmetic helpers used by the star pool.
// ============================================================================
package tspl_pkg;

    // Request codes carried on the func input.
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    // Star colour codes.
    localparam logic [1:0] COL_WHITE = 2'd0;
    localparam logic [1:0] COL_WARM  = 2'd1;
    localparam logic [1:0] COL_PALE  = 2'd2;

    // Minimum time between two spawns, in milliseconds.
    localparam logic [31:0] SPAWN_GAP_MS = 32'd300;

    // Full brightness of the envelope.
    localparam logic [7:0] LEVEL_FULL = 8'd255;

    // floor(x / 3) for x below 4096 is (x * 2731) >> 13.
    localparam logic [11:0] THIRD_RECIP = 12'd2731;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_T_SLOT,
        S_T_LOAD,
        S_T_CALC,
        S_T_SETUP,
        S_T_DIV,
        S_T_WB,
        S_P_SCAN,
        S_P_LOAD,
        S_OUT
    } t_state;

    // One star slot as kept in the slot memory.
    typedef struct packed {
        logic [15:0] position;
        logic [1:0]  colour;
        logic [31:0] start;
        logic [11:0] lifetime;
        logic [7:0]  level;
    } t_slot;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Night sky background colour.
    localparam t_rgb SKY_RGB = '{red: 8'd5, green: 8'd5, blue: 8'd40};

    // Base colour of a star; the unused code shows as pale yellow.
    function automatic t_rgb star_rgb(input logic [1:0] colour);
        t_rgb c;
        unique case (colour)
            COL_WHITE: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            COL_WARM:  c = '{red: 8'd255, green: 8'd255, blue: 8'd200};
            default:   c = '{red: 8'd255, green: 8'd240, blue: 8'd150};
        endcase
        return c;
    endfunction

    // Video-mode scaling: a lit channel never drops to zero at a nonzero level.
    function automatic logic [7:0] video_scale(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] p;
        p = c * s;
        if (c == 8'd0) begin
            return 8'd0;
        end
        return p[15:8] + {7'd0, (s != 8'd0)};
    endfunction

    // One third of a lifetime, rounded down.
    function automatic logic [11:0] third_of(input logic [11:0] life);
        logic [23:0] p;
        p = life * THIRD_RECIP;
        return {1'b0, p[23:13]};
    endfunction

endpackage

/* rtl/core/twinkling_star_pool_led_effect_top.sv */
// ============================================================================
// twinkling_star_pool_led_effect_top: pool of twinkling stars over a sky strip.
// Frame ticks spawn, age and end stars; pixel reads return an LED's colour.
// ============================================================================
//
// One item is taken when start is high and busy is low, and its single result
// shows on the result ports for one cycle with o_strobe high. A frame tick
// walks the slot memory one slot at a time: a free slot is skipped unless a
// spawn takes it, and a live slot is loaded and aged; its brightness comes
// from an 8-bit quotient that one shared restoring divider forms one bit per
// cycle (a slot that holds at full level skips the divider, and one that
// ends is freed without a write). A pixel read scans the slots with one slot
// memory read per live slot and then forms its result; a read beyond the
// strip skips the scan. The result cannot be held off by the receiver.
// The num_leds register is written while the block is idle; each write
// clears all stars.
//
module twinkling_star_pool_led_effect_top
    import tspl_pkg::*;
#(
    parameter int STAR_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_elapsed_ms,
    input  logic [15:0] i_rand_position,
    input  logic [1:0]  i_rand_colour,
    input  logic [11:0] i_rand_duration,
    input  logic [15:0] i_pixel_index,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_star_lit
);

    localparam int IW = (STAR_SLOTS > 1) ? $clog2(STAR_SLOTS) : 1;
    localparam int CW = $clog2(STAR_SLOTS + 1);

    // Control state.
    t_state                  r_state, n_state;
    logic [15:0]             r_num_leds;
    logic [STAR_SLOTS-1:0]   r_active;
    logic [31:0]             r_last;
    logic [CW-1:0]           r_cnt;
    logic                    r_pending;
    logic                    r_strobe;

    // Captured item.
    logic                    r_func;
    logic [31:0]             r_now;
    logic [15:0]             r_pos;
    logic [1:0]              r_col;
    logic [11:0]             r_dur;
    logic [15:0]             r_px;

    // Slot working copy and envelope datapath.
    t_slot                   r_work;
    t_slot                   r_rd;
    t_slot                   r_mem [STAR_SLOTS];
    logic [11:0]             r_age;
    logic                    r_dead;
    logic [11:0]             r_third;
    logic [19:0]             r_rem;
    logic [18:0]             r_dsh;
    logic [7:0]              r_q;
    logic [2:0]              r_bit;
    logic                    r_fade;

    // Pixel read result.
    logic                    r_hit;
    logic [1:0]              r_hcol;
    logic [7:0]              r_hlvl;

    // Output registers.
    logic [7:0]              r_red, r_green, r_blue;
    logic                    r_lit;

    // Decoded control.
    logic                    accept;
    logic                    cfg_we;
    logic                    mem_we;
    logic                    cnt_inc;
    logic                    at_end;
    logic                    cur_active;
    logic                    do_spawn;
    logic                    spawn_due;
    logic [IW-1:0]           w_idx;

    // Envelope arithmetic.
    logic [31:0]             age_full;
    logic                    dead_now;
    logic [12:0]             two_third;
    logic [11:0]             two_third_s;
    logic [19:0]             ramp_num;
    logic [11:0]             fade_age;
    logic [19:0]             fade_num;
    logic [11:0]             fade_len;
    logic                    in_ramp;
    logic                    in_hold;
    logic [19:0]             trial;
    logic                    div_ge;
    logic [7:0]              new_level;
    t_slot                   wr_slot;
    t_rgb                    base_rgb;

    // Slot pointer and its status.
    assign w_idx      = r_cnt[IW-1:0];
    assign at_end     = (r_cnt == CW'(STAR_SLOTS));
    assign cur_active = r_active[w_idx];
    assign do_spawn   = r_pending && !cur_active;

    // A tick is due to spawn once the spawn gap has passed since the last one.
    assign spawn_due = (i_func == FUNC_TICK) && ((i_elapsed_ms - r_last) >= SPAWN_GAP_MS);

    // Age of the slot and the envelope break points.
    assign age_full    = r_now - r_work.start;
    assign dead_now    = (age_full >= {20'd0, r_work.lifetime});
    assign two_third   = {r_third, 1'b0};
    assign two_third_s = two_third[11:0];
    assign in_ramp     = (r_age < r_third);
    assign in_hold     = ({1'b0, r_age} < two_third);
    assign ramp_num    = {r_age, 8'd0} - {8'd0, r_age};
    assign fade_age    = r_age - two_third_s;
    assign fade_num    = {fade_age, 8'd0} - {8'd0, fade_age};
    assign fade_len    = r_work.lifetime - two_third_s;

    // One restoring step of the shared divider.
    assign trial     = {1'b0, r_dsh};
    assign div_ge    = (r_rem >= trial);
    assign new_level = r_fade ? (LEVEL_FULL - r_q) : r_q;

    always_comb begin
        wr_slot       = r_work;
        wr_slot.level = new_level;
    end

    assign base_rgb = star_rgb(r_hcol);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_func == FUNC_TICK) begin
                        n_state = S_T_SLOT;
                    end else if (i_pixel_index >= r_num_leds) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_P_SCAN;
                    end
                end
            end
            S_T_SLOT: begin
                if (at_end) begin
                    n_state = S_OUT;
                end else if (do_spawn) begin
                    n_state = S_T_CALC;
                end else if (cur_active) begin
                    n_state = S_T_LOAD;
                end
            end
            S_T_LOAD:  n_state = S_T_CALC;
            S_T_CALC:  n_state = S_T_SETUP;
            S_T_SETUP: begin
                if (r_dead) begin
                    n_state = S_T_SLOT;
                end else if (in_ramp || !in_hold) begin
                    n_state = S_T_DIV;
                end else begin
                    n_state = S_T_WB;
                end
            end
            S_T_DIV: begin
                if (r_bit == 3'd0) begin
                    n_state = S_T_WB;
                end
            end
            S_T_WB:    n_state = S_T_SLOT;
            S_P_SCAN: begin
                if (at_end) begin
                    n_state = S_OUT;
                end else if (cur_active) begin
                    n_state = S_P_LOAD;
                end
            end
            S_P_LOAD:  n_state = S_P_SCAN;
            S_OUT:     n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        busy        = (r_state != S_IDLE);
        o_cfg_ready = (r_state == S_IDLE);
        accept      = start && (r_state == S_IDLE);
        cfg_we      = i_cfg_valid && (r_state == S_IDLE);
        mem_we      = (r_state == S_T_WB);
        cnt_inc     = 1'b0;
        unique case (r_state)
            S_T_SLOT:  cnt_inc = !at_end && !do_spawn && !cur_active;
            S_T_SETUP: cnt_inc = r_dead;
            S_T_WB:    cnt_inc = 1'b1;
            S_P_SCAN:  cnt_inc = !at_end && !cur_active;
            S_P_LOAD:  cnt_inc = 1'b1;
            default:   cnt_inc = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_num_leds <= '0;
            r_active   <= '0;
            r_last     <= '0;
            r_cnt      <= '0;
            r_pending  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_OUT);
            if (cfg_we) begin
                r_num_leds <= i_cfg_data;
                r_active   <= '0;
            end
            if (accept) begin
                r_cnt     <= '0;
                r_pending <= spawn_due;
                if (spawn_due) begin
                    r_last <= i_elapsed_ms;
                end
            end else if (cnt_inc) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end
            // A spawn takes the lowest free slot; an expired star frees its slot.
            if (r_state == S_T_SLOT && !at_end && do_spawn) begin
                r_pending       <= 1'b0;
                r_active[w_idx] <= 1'b1;
            end
            if (r_state == S_T_SETUP && r_dead) begin
                r_active[w_idx] <= 1'b0;
            end
        end
    end

    // Item capture and the envelope datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_now  <= i_elapsed_ms;
            r_pos  <= i_rand_position;
            r_col  <= i_rand_colour;
            r_dur  <= i_rand_duration;
            r_px   <= i_pixel_index;
            r_hit  <= 1'b0;
        end
        unique case (r_state)
            S_T_SLOT: begin
                r_work <= '{position: r_pos, colour: r_col, start: r_now,
                            lifetime: r_dur, level: 8'd0};
            end
            S_T_LOAD: begin
                r_work <= r_rd;
            end
            S_T_CALC: begin
                r_age   <= age_full[11:0];
                r_dead  <= dead_now;
                r_third <= third_of(r_work.lifetime);
            end
            S_T_SETUP: begin
                r_bit <= 3'd7;
                if (in_ramp) begin
                    r_rem  <= ramp_num;
                    r_dsh  <= {r_third, 7'd0};
                    r_fade <= 1'b0;
                    r_q    <= 8'd0;
                end else if (in_hold) begin
                    r_fade <= 1'b0;
                    r_q    <= LEVEL_FULL;
                end else begin
                    r_rem  <= fade_num;
                    r_dsh  <= {fade_len, 7'd0};
                    r_fade <= 1'b1;
                    r_q    <= 8'd0;
                end
            end
            S_T_DIV: begin
                if (div_ge) begin
                    r_rem <= r_rem - trial;
                end
                r_q   <= {r_q[6:0], div_ge};
                r_dsh <= r_dsh >> 1;
                r_bit <= r_bit - 3'd1;
            end
            S_P_LOAD: begin
                // The highest matching slot wins, so later hits overwrite.
                if (r_rd.position == r_px) begin
                    r_hit  <= 1'b1;
                    r_hcol <= r_rd.colour;
                    r_hlvl <= r_rd.level;
                end
            end
            default: begin
            end
        endcase
    end

    // Slot memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[w_idx] <= wr_slot;
        end
        r_rd <= r_mem[w_idx];
    end

    // Result formation.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            if (r_func == FUNC_TICK || r_px >= r_num_leds) begin
                r_red   <= 8'd0;
                r_green <= 8'd0;
                r_blue  <= 8'd0;
                r_lit   <= 1'b0;
            end else if (r_hit) begin
                r_red   <= video_scale(base_rgb.red, r_hlvl);
                r_green <= video_scale(base_rgb.green, r_hlvl);
                r_blue  <= video_scale(base_rgb.blue, r_hlvl);
                r_lit   <= 1'b1;
            end else begin
                r_red   <= SKY_RGB.red;
                r_green <= SKY_RGB.green;
                r_blue  <= SKY_RGB.blue;
                r_lit   <= 1'b0;
            end
        end
    end

    assign o_strobe   = r_strobe;
    assign o_red      = r_red;
    assign o_green    = r_green;
    assign o_blue     = r_blue;
    assign o_star_lit = r_lit;

endmodule

/* rtl/core/tspl_checker.sv */
// ============================================================================
// tspl_checker: port-level checks for the twinkling star pool.
// Watches the command handshake, the result strobe and the result values.
// ============================================================================
module tspl_checker
    import tspl_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_cfg_ready,
    input logic       o_strobe,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue,
    input logic       o_star_lit
);

    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // The block only goes idle together with delivering a result.
    a_fall_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("block went idle without a result");

    // Results are never shown on consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held for more than one cycle");

    // Configuration is offered only while no item is at work.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready |-> !busy)
        else $error("configuration offered while busy");

    // An unlit result is either the sky colour or all zero.
    a_unlit_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_star_lit) |->
            ((o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0) ||
             (o_red == SKY_RGB.red && o_green == SKY_RGB.green &&
              o_blue == SKY_RGB.blue)))
        else $error("unlit result has an unexpected colour");

endmodule

bind twinkling_star_pool_led_effect_top tspl_checker u_tspl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_cfg_ready (o_cfg_ready),
    .o_strobe    (o_strobe),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue),
    .o_star_lit  (o_star_lit)
);

/* tb/tspl_pool_checker.sv */
// ============================================================================
// tspl_pool_checker: predicts and checks the results of the star pool.
// It watches the item, register and result channels of the block. It keeps
// its own copy of the star slots, forms the pixel colour that each item
// should return, and compares every result with the oldest expected one.
// ============================================================================
module tspl_pool_checker
    import tspl_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_func,
    input  logic [31:0] i_elapsed_ms,
    input  logic [15:0] i_rand_position,
    input  logic [1:0]  i_rand_colour,
    input  logic [11:0] i_rand_duration,
    input  logic [15:0] i_pixel_index,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_strobe,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    input  logic        i_star_lit,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_lit_reads
);

    // Colour and lit flag that one item returns.
    typedef struct packed {
        t_rgb rgb;
        logic lit;
    } pixel_t;

    pixel_t pending_pixels[$];
    pixel_t seen_px;
    pixel_t want_px;

    // Shadow copy of the star pool.
    logic        star_live  [NUM_SLOTS];
    logic [15:0] star_pos   [NUM_SLOTS];
    logic [1:0]  star_col   [NUM_SLOTS];
    logic [31:0] star_born  [NUM_SLOTS];
    logic [11:0] star_life  [NUM_SLOTS];
    logic [7:0]  star_level [NUM_SLOTS];
    logic [31:0] last_spawn;
    logic [15:0] strip_len;

    // Brightness envelope: ramp up, hold at full, ramp down, by thirds.
    function automatic logic [7:0] star_brightness(input logic [31:0] age,
                                                   input logic [11:0] life);
        logic [31:0] third;
        logic [31:0] ramp;
        logic [31:0] span;
        logic [31:0] q;
        third = {20'd0, life} / 32'd3;
        if (age < third) begin
            q = (age * 32'd255) / third;
            return q[7:0];
        end
        if (age < third * 32'd2) begin
            return LEVEL_FULL;
        end
        ramp = age - third * 32'd2;
        span = {20'd0, life} - third * 32'd2;
        q = 32'd255 - (ramp * 32'd255) / span;
        return q[7:0];
    endfunction

    // Video dimming keeps a lit channel above zero at any nonzero level.
    function automatic logic [7:0] dim_channel(input logic [7:0] c, input logic [7:0] s);
        logic [15:0] prod;
        prod = {8'd0, c} * {8'd0, s};
        if (c == 8'd0) begin
            return 8'd0;
        end
        if (s != 8'd0) begin
            return prod[15:8] + 8'd1;
        end
        return prod[15:8];
    endfunction

    // Base colour of a star; the spare code shows as pale yellow.
    function automatic t_rgb base_colour(input logic [1:0] code);
        t_rgb c;
        case (code)
            COL_WHITE: c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
            COL_WARM:  c = '{red: 8'd255, green: 8'd255, blue: 8'd200};
            default:   c = '{red: 8'd255, green: 8'd240, blue: 8'd150};
        endcase
        return c;
    endfunction

    // One frame: spawn when due, then end old stars and latch levels.
    task advance_frame(input logic [31:0] now, input logic [15:0] pos,
                       input logic [1:0] col, input logic [11:0] dur);
        logic [31:0] since_spawn;
        logic [31:0] age;
        logic        placed;
        since_spawn = now - last_spawn;
        placed = 1'b0;
        if (since_spawn >= SPAWN_GAP_MS) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (!star_live[k] && !placed) begin
                    star_live[k]  = 1'b1;
                    star_pos[k]   = pos;
                    star_col[k]   = col;
                    star_born[k]  = now;
                    star_life[k]  = dur;
                    star_level[k] = 8'd0;
                    placed = 1'b1;
                end
            end
            last_spawn = now;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (star_live[k]) begin
                age = now - star_born[k];
                if (age >= {20'd0, star_life[k]}) begin
                    star_live[k] = 1'b0;
                end else begin
                    star_level[k] = star_brightness(age, star_life[k]);
                end
            end
        end
    endtask

    // Colour at one LED: the highest live slot there wins, else the sky; beyond the strip it is all zero.
    function automatic pixel_t pixel_at(input logic [15:0] px);
        pixel_t p;
        t_rgb   c;
        int     hit;
        p = '0;
        hit = -1;
        if (px >= strip_len) begin
            return p;
        end
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (star_live[k] && star_pos[k] == px) begin
                hit = k;
            end
        end
        if (hit < 0) begin
            p.rgb = SKY_RGB;
            p.lit = 1'b0;
        end else begin
            c = base_colour(star_col[hit]);
            p.rgb.red   = dim_channel(c.red,   star_level[hit]);
            p.rgb.green = dim_channel(c.green, star_level[hit]);
            p.rgb.blue  = dim_channel(c.blue,  star_level[hit]);
            p.lit = 1'b1;
        end
        return p;
    endfunction

    // Results are checked before a new item is taken at the same edge, since
    // a result at that edge belongs to an earlier item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                star_live[k]  = 1'b0;
                star_pos[k]   = '0;
                star_col[k]   = '0;
                star_born[k]  = '0;
                star_life[k]  = '0;
                star_level[k] = '0;
            end
            last_spawn = '0;
            strip_len = '0;
            pending_pixels.delete();
            o_fail_count = 0;
            o_lit_reads = 0;
        end else begin
            if (i_strobe) begin
                seen_px.rgb = '{red: i_red, green: i_green, blue: i_blue};
                seen_px.lit = i_star_lit;
                if (pending_pixels.size() == 0) begin
                    $error("result with no item waiting: rgb %0d,%0d,%0d lit %0d",
                           i_red, i_green, i_blue, i_star_lit);
                    o_fail_count++;
                end else begin
                    want_px = pending_pixels.pop_front();
                    if (seen_px.rgb.red !== want_px.rgb.red) begin
                        $error("red: expected %0d, got %0d", want_px.rgb.red, seen_px.rgb.red);
                        o_fail_count++;
                    end
                    if (seen_px.rgb.green !== want_px.rgb.green) begin
                        $error("green: expected %0d, got %0d",
                               want_px.rgb.green, seen_px.rgb.green);
                        o_fail_count++;
                    end
                    if (seen_px.rgb.blue !== want_px.rgb.blue) begin
                        $error("blue: expected %0d, got %0d", want_px.rgb.blue, seen_px.rgb.blue);
                        o_fail_count++;
                    end
                    if (seen_px.lit !== want_px.lit) begin
                        $error("star_lit: expected %0d, got %0d", want_px.lit, seen_px.lit);
                        o_fail_count++;
                    end
                end
            end

            // A strip length write clears every star.
            if (i_cfg_valid && i_cfg_ready) begin
                strip_len = i_cfg_data;
                for (int k = 0; k < NUM_SLOTS; k++) begin
                    star_live[k] = 1'b0;
                end
            end

            if (i_start && !i_busy) begin
                if (i_func == FUNC_TICK) begin
                    advance_frame(i_elapsed_ms, i_rand_position, i_rand_colour,
                                  i_rand_duration);
                    pending_pixels.push_back('0);
                end else begin
                    want_px = pixel_at(i_pixel_index);
                    if (want_px.lit) begin
                        o_lit_reads++;
                    end
                    pending_pixels.push_back(want_px);
                end
            end
        end
        o_pending = pending_pixels.size();
    end

endmodule

/* tb/tb_top.sv */
// ============================================================================
// tb_top: stimulus and verdict for the twinkling star pool.
// Drives frame ticks and pixel reads with random gaps, rewrites the strip
// length between phases, and crowds the pool until it is full. The checker
// beside the block predicts and compares every result.
// ============================================================================
module tb_top;
    import tspl_pkg::*;

    localparam int SLOTS = 16;
    localparam int LIMIT = 2_000_000;
    localparam int DRAIN = 400;
    localparam int PHASE_ITEMS = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [31:0] i_elapsed_ms;
    logic [15:0] i_rand_position;
    logic [1:0]  i_rand_colour;
    logic [11:0] i_rand_duration;
    logic [15:0] i_pixel_index;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data;
    logic        o_strobe;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_star_lit;

    int unsigned fail_total;
    int unsigned pending;
    int unsigned lit_reads;

    // Stimulus bookkeeping.
    logic [31:0] now_ms;
    logic [15:0] strip;
    logic [15:0] recent_pos[$];
    int unsigned ticks_sent;
    int unsigned reads_sent;
    int unsigned cfg_writes;
    int          calm_left;
    int          strips[6];

    twinkling_star_pool_led_effect_top #(
        .STAR_SLOTS(SLOTS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_rand_position(i_rand_position),
        .i_rand_colour  (i_rand_colour),
        .i_rand_duration(i_rand_duration),
        .i_pixel_index  (i_pixel_index),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_star_lit     (o_star_lit)
    );

    tspl_pool_checker #(
        .NUM_SLOTS(SLOTS)
    ) pool_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_func         (i_func),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_rand_position(i_rand_position),
        .i_rand_colour  (i_rand_colour),
        .i_rand_duration(i_rand_duration),
        .i_pixel_index  (i_pixel_index),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_strobe       (o_strobe),
        .i_red          (o_red),
        .i_green        (o_green),
        .i_blue         (o_blue),
        .i_star_lit     (o_star_lit),
        .o_fail_count   (fail_total),
        .o_pending      (pending),
        .o_lit_reads    (lit_reads)
    );

    // Clock with a period of 12.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Idle length before an item: mostly short, a few long, with calm runs.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 3) begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (r < 45) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(3, 1);
        end
        if (r < 97) begin
            return $urandom_range(15, 4);
        end
        return $urandom_range(120, 30);
    endfunction

    // Offer one item and hold it until the block takes it.
    task send_item(input logic func, input logic [31:0] ms, input logic [15:0] pos,
                   input logic [1:0] col, input logic [11:0] dur, input logic [15:0] px);
        int   gap;
        logic taken;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func = func;
        i_elapsed_ms = ms;
        i_rand_position = pos;
        i_rand_colour = col;
        i_rand_duration = dur;
        i_pixel_index = px;
        start = 1'b1;
        do begin
            @(posedge i_clk);
            taken = !busy;
            @(negedge i_clk);
        end while (!taken);
        if (func == FUNC_TICK) begin
            ticks_sent++;
            recent_pos.push_back(pos);
            if (recent_pos.size() > 8) begin
                void'(recent_pos.pop_front());
            end
        end else begin
            reads_sent++;
        end
    endtask

    // Frame tick; the pixel field carries noise.
    task tick(input logic [31:0] ms, input logic [15:0] pos, input logic [1:0] col,
              input logic [11:0] dur);
        send_item(FUNC_TICK, ms, pos, col, dur, 16'($urandom_range(65535)));
    endtask

    // Pixel read; the tick fields carry noise.
    task peek(input logic [15:0] px);
        send_item(FUNC_PIXEL, $urandom, 16'($urandom_range(65535)),
                  2'($urandom_range(3)), 12'($urandom_range(4095)), px);
    endtask

    // Stop offering items until every result is back.
    task settle();
        start = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Write the strip length once the block is idle.
    task write_strip(input logic [15:0] value);
        logic ok;
        settle();
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
            ok = o_cfg_ready;
            @(negedge i_clk);
        end while (!ok);
        i_cfg_valid = 1'b0;
        strip = value;
        recent_pos.delete();
        cfg_writes++;
    endtask

    function automatic logic [15:0] pick_pos();
        if (strip == 16'd0) begin
            return 16'($urandom_range(65535));
        end
        return 16'($urandom_range(strip - 1));
    endfunction

    // Reads mostly land on positions that recent frame ticks carried.
    function automatic logic [15:0] pick_pixel();
        int r;
        r = $urandom_range(99);
        if (r < 60 && recent_pos.size() > 0) begin
            return recent_pos[$urandom_range(recent_pos.size() - 1)];
        end
        if (r < 85) begin
            return pick_pos();
        end
        return 16'($urandom_range(65535));
    endfunction

    // Fill the pool: each forward tick spawns a star that the following
    // backward tick ends while spawning an older one, so one star is gained
    // per pair of ticks until no slot is free.
    task crowd_pool();
        logic [31:0] base;
        int          step;
        base = now_ms + 32'd300;
        step = $urandom_range(120, 30);
        for (int k = 0; k < SLOTS + 2; k++) begin
            tick(base + k * step + 400, pick_pos(), 2'($urandom_range(2)),
                 12'($urandom_range(3999, 2500)));
            tick(base + k * step, pick_pos(), 2'($urandom_range(2)),
                 12'($urandom_range(3999, 2500)));
            peek(pick_pixel());
        end
        now_ms = base + (SLOTS + 2) * step;
    endtask

    // One random item: mostly well-paced ticks and reads, some noise ticks.
    task random_item();
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            if ($urandom_range(4) == 0) begin
                now_ms = now_ms + $urandom_range(700, 280);
            end else begin
                now_ms = now_ms + $urandom_range(120, 16);
            end
            tick(now_ms, pick_pos(), 2'($urandom_range(2)), 12'($urandom_range(3999, 1500)));
        end else if (r < 53) begin
            case ($urandom_range(2))
                0: now_ms = $urandom;
                1: now_ms = now_ms - $urandom_range(400, 1);
                default: now_ms = now_ms + $urandom_range(299);
            endcase
            tick(now_ms, 16'($urandom_range(65535)), 2'($urandom_range(3)),
                 12'($urandom_range(4095)));
        end else begin
            peek(pick_pixel());
        end
    endtask

    // Main stimulus.
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_func = FUNC_TICK;
        i_elapsed_ms = '0;
        i_rand_position = '0;
        i_rand_colour = COL_WHITE;
        i_rand_duration = '0;
        i_pixel_index = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        now_ms = '0;
        strip = '0;
        ticks_sent = 0;
        reads_sent = 0;
        cfg_writes = 0;
        calm_left = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. With no strip every read falls beyond it.
        peek(16'd0);
        write_strip(16'd16);
        tick(32'd0, 16'd2, COL_WHITE, 12'd2000);
        // A star read in its spawn frame is lit but black.
        tick(32'd300, 16'd3, COL_WHITE, 12'd1500);
        peek(16'd3);
        peek(16'd4);
        tick(32'd400, 16'd9, COL_WARM, 12'd1500);
        peek(16'd3);
        // Colour code three and an oversized lifetime on the same LED.
        tick(32'd700, 16'd3, 2'd3, 12'd4095);
        peek(16'd3);
        // Zero lifetime ends at once.
        tick(32'd1000, 16'd15, COL_WARM, 12'd0);
        peek(16'd15);
        // Position beyond the strip, then the shortest fading lifetimes.
        tick(32'd1300, 16'hFFFF, COL_PALE, 12'd1);
        tick(32'd1600, 16'd5, COL_PALE, 12'd2);
        peek(16'd5);
        tick(32'd1601, 16'd6, COL_WHITE, 12'd3999);
        peek(16'd5);
        peek(16'd16);
        peek(16'hFFFF);
        // The first star reaches its lifetime here.
        tick(32'd1800, 16'd4, COL_WHITE, 12'd1500);
        peek(16'd3);
        // Time wraps past the top of the counter.
        tick(32'hFFFF_FF00, 16'd7, COL_WHITE, 12'd3999);
        tick(32'h0000_0050, 16'd8, COL_WARM, 12'd3000);
        peek(16'd7);
        peek(16'd8);
        now_ms = 32'h0000_0050;

        // Random phases over several strip lengths, the single and the longest strip first.
        strips[0] = 1;
        strips[1] = 65535;
        strips[2] = $urandom_range(48, 8);
        strips[3] = 0;
        strips[4] = 16;
        strips[5] = $urandom_range(65535);
        for (int ph = 0; ph < 6; ph++) begin
            write_strip(16'(strips[ph]));
            if (ph == 2 || ph == 4) begin
                crowd_pool();
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
                if ($urandom_range(49) == 0) begin
                    settle();
                end
            end
            settle();
        end

        // Let any stray result show up before the verdict.
        settle();
        repeat (DRAIN) @(negedge i_clk);
        $display("Covered %0d frame ticks and %0d pixel reads, %0d of them on a lit star,",
                 ticks_sent, reads_sent, lit_reads);
        $display("over %0d strip length writes including empty, single and full strips.",
                 cfg_writes);
        if (fail_total == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* twinkling_star_pool_led_effect_top.f */
rtl/core/tspl_pkg.sv
rtl/core/twinkling_star_pool_led_effect_top.sv
rtl/core/tspl_checker.sv
tb/tspl_pool_checker.sv
tb/tb_top.sv
